// ----- src/lsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types, register indexes and byte helpers for the line substring filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PAT_REGS   = 4;
   localparam int PAT_BYTES  = 8 * PAT_REGS;
   localparam int LEN_REG_W  = 6;
   localparam int LEN_W      = 7;
   localparam int COUNT_W    = 32;

   localparam logic [7:0] LF_BYTE  = 8'h0A;
   localparam logic [7:0] NUL_BYTE = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAT_LO     = 3'd0,
      CSR_PAT_MID_LO = 3'd1,
      CSR_PAT_MID_HI = 3'd2,
      CSR_PAT_HI     = 3'd3,
      CSR_PAT_LEN    = 3'd4,
      CSR_FOLD_CASE  = 3'd5,
      CSR_INVERT     = 3'd6
   } csr_index_type;

   typedef logic [COUNT_W-1:0] count_type;

   // ascii upper case to lower case when folding is on
   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

// ----- src/line_substring_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_filter
// Fixed-string line filter: one text byte per transaction, one report per line.
// ----------------------------------------------------------------------------
// Takes one text byte per clock and reports each finished line (LF, a split
// after LINE_BUFFER-1 bytes, or a flush on end_of_input) with its selected
// flag, line number and running selected count. Every byte is handled in the
// cycle it is accepted: the window shift, the parallel compare of up to
// PATTERN_MAX bytes against the pattern and the flag and counter updates all
// sit between the line state registers and the result register, so the
// block takes one transaction per clock. The input stalls only while the
// result register holds a report that the result side is stalling.
// Pattern registers are written over the csr port, which is always ready;
// write them only while no transaction is in flight.
module line_substring_filter #(
   parameter int PATTERN_MAX = 32,
   parameter int LINE_BUFFER = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_end_of_input,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_line_valid,
   output logic                              rsp_line_selected,
   output logic [31:0]                       rsp_line_number,
   output logic [31:0]                       rsp_selected_total,
   output logic                              rsp_final_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lsf_pkg::*;

   localparam int CNT_W = (LINE_BUFFER > 1) ? $clog2(LINE_BUFFER) : 1;
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CNT_W-1:0] LINE_MAX = CNT_W'(LINE_BUFFER - 1);
   localparam logic [LEN_W-1:0] PAT_MAX_LEN = LEN_W'(PATTERN_MAX);

   // configuration
   logic [CSR_DATA_W-1:0] pat_reg_ff [PAT_REGS];
   logic [LEN_REG_W-1:0]  pat_len_ff;
   logic                  fold_case_ff;
   logic                  invert_ff;

   // line state
   logic [7:0]       window_ff [PATTERN_MAX];
   logic [7:0]       window_in [PATTERN_MAX];
   logic [CNT_W-1:0] bytes_ff, bytes_in;
   logic             found_ff, found_in;
   logic             nul_ff, nul_in;
   count_type        lines_ff, lines_in;
   count_type        selected_ff, selected_in;
   logic             shift_en;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             line_valid_ff, line_valid_in;
   logic             line_sel_ff, line_sel_in;
   count_type        line_num_ff, line_num_in;
   count_type        sel_total_ff, sel_total_in;
   logic             final_ff, final_in;

   logic                     accept;
   logic [PAT_BYTES*8-1:0]   pat_vec;
   logic [LEN_W-1:0]         len_eff;
   logic [CNT_W-1:0]         bytes_next;
   logic [PATTERN_MAX-1:0]   byte_ok;
   logic                     hit;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pat_vec = {pat_reg_ff[3], pat_reg_ff[2], pat_reg_ff[1], pat_reg_ff[0]};
   assign len_eff = ({1'b0, pat_len_ff} > PAT_MAX_LEN) ? PAT_MAX_LEN : {1'b0, pat_len_ff};
   assign bytes_next = (bytes_ff == LINE_MAX) ? bytes_ff : bytes_ff + 1'b1;

   always_comb begin
      window_in[0] = req_data_byte;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // window entry j lines up with pattern byte len-1-j
   always_comb begin
      logic [LEN_W-1:0] pidx;
      logic [7:0]       pbyte;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pidx  = len_eff - LEN_W'(j) - LEN_W'(1);
         pbyte = (pidx < LEN_W'(PAT_BYTES)) ? pat_vec[8*pidx[4:0] +: 8] : NUL_BYTE;
         byte_ok[j] = (LEN_W'(j) >= len_eff) ||
                      (fold_byte(window_in[j], fold_case_ff) == fold_byte(pbyte, fold_case_ff));
      end
   end

   assign hit = (len_eff != '0) &&
                (CMP_W'(bytes_next) >= CMP_W'(len_eff)) && (&byte_ok);

   always_comb begin
      logic      found_line;
      logic      sel;
      count_type lines_inc;
      count_type sel_inc;
      logic      line_end;

      bytes_in      = bytes_ff;
      found_in      = found_ff;
      nul_in        = nul_ff;
      lines_in      = lines_ff;
      selected_in   = selected_ff;
      shift_en      = 1'b0;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      line_valid_in = line_valid_ff;
      line_sel_in   = line_sel_ff;
      line_num_in   = line_num_ff;
      sel_total_in  = sel_total_ff;
      final_in      = final_ff;
      line_end      = 1'b0;
      found_line    = found_ff;

      if (accept && !req_end_of_input && req_data_byte != LF_BYTE) begin
         shift_en = 1'b1;
         bytes_in = bytes_next;
         if (req_data_byte == NUL_BYTE) begin
            nul_in = 1'b1;
         end else if (!nul_ff && hit) begin
            found_in = 1'b1;
         end
         found_line = found_in;
         line_end   = (bytes_next == LINE_MAX);
      end else if (accept) begin
         line_end = !req_end_of_input || (bytes_ff != '0);
      end

      found_line = found_line || (len_eff == '0);
      sel        = found_line ^ invert_ff;
      lines_inc  = (lines_ff == '1) ? lines_ff : lines_ff + 1'b1;
      sel_inc    = (sel && selected_ff != '1) ? selected_ff + 1'b1 : selected_ff;

      if (line_end) begin
         lines_in      = lines_inc;
         selected_in   = sel_inc;
         bytes_in      = '0;
         found_in      = 1'b0;
         nul_in        = 1'b0;
         rsp_valid_in  = 1'b1;
         line_valid_in = 1'b1;
         line_sel_in   = sel;
         line_num_in   = lines_inc;
         sel_total_in  = sel_inc;
         final_in      = req_end_of_input;
      end else if (accept && req_end_of_input) begin
         // end of input with no partial line
         rsp_valid_in  = 1'b1;
         line_valid_in = 1'b0;
         line_sel_in   = 1'b0;
         line_num_in   = lines_ff;
         sel_total_in  = selected_ff;
         final_in      = 1'b1;
      end

      if (accept && req_end_of_input) begin
         lines_in = '0;
         bytes_in = '0;
         found_in = 1'b0;
         nul_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < PAT_REGS; r++) begin
            pat_reg_ff[r] <= '0;
         end
         pat_len_ff   <= '0;
         fold_case_ff <= 1'b0;
         invert_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAT_LO:     pat_reg_ff[0] <= csr_wdata;
            CSR_PAT_MID_LO: pat_reg_ff[1] <= csr_wdata;
            CSR_PAT_MID_HI: pat_reg_ff[2] <= csr_wdata;
            CSR_PAT_HI:     pat_reg_ff[3] <= csr_wdata;
            CSR_PAT_LEN:    pat_len_ff    <= csr_wdata[LEN_REG_W-1:0];
            CSR_FOLD_CASE:  fold_case_ff  <= csr_wdata[0];
            CSR_INVERT:     invert_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff     <= '0;
         found_ff     <= 1'b0;
         nul_ff       <= 1'b0;
         lines_ff     <= '0;
         selected_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bytes_ff     <= bytes_in;
         found_ff     <= found_in;
         nul_ff       <= nul_in;
         lines_ff     <= lines_in;
         selected_ff  <= selected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window entries past the line start never reach the compare
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            window_ff[j] <= window_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      line_valid_ff <= line_valid_in;
      line_sel_ff   <= line_sel_in;
      line_num_ff   <= line_num_in;
      sel_total_ff  <= sel_total_in;
      final_ff      <= final_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_valid     = line_valid_ff;
   assign rsp_line_selected  = line_sel_ff;
   assign rsp_line_number    = line_num_ff;
   assign rsp_selected_total = sel_total_ff;
   assign rsp_final_res      = final_ff;

   a_eoi_clears_line: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_input |=> bytes_ff == '0 && lines_ff == '0 && !found_ff)
      else $error("line state not cleared after end of input");

   a_line_number_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && line_valid_ff |-> line_num_ff != '0)
      else $error("reported line has number zero");

   a_empty_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !line_valid_ff |-> final_ff && !line_sel_ff)
      else $error("non-line transaction is not a clean end of input");

   a_split_limit: assert property (@(posedge clock) disable iff (reset)
      bytes_ff != LINE_MAX)
      else $error("line byte count reached the split length without a report");

endmodule

// ----- test/line_substring_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_filter_tb
// Self-checking bench for the fixed-string line filter.
// ----------------------------------------------------------------------------
// A line model inside the bench tracks the byte window, line flags and
// counters and predicts every line report. Directed tests cover matches with
// case folding, empty lines, NUL, flushes at end of input, an empty pattern,
// inverted selection and a CR in the pattern. Further tests cover split lines
// and a long result back-pressure. Random traffic then runs through many
// pattern settings with random gaps on both channels.
module line_substring_filter_tb;
   import lsf_pkg::*;

   localparam int PAT_MAX      = 32;
   localparam int LINE_MAX     = 512;
   localparam int DRAIN_CYCLES = 8;
   localparam int STUCK_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 200;

   typedef struct {
      logic      line_valid;
      logic      line_selected;
      count_type line_number;
      count_type selected_total;
      logic      final_res;
   } line_report_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_data_byte;
   logic                  req_end_of_input;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_line_valid;
   logic                  rsp_line_selected;
   logic [31:0]           rsp_line_number;
   logic [31:0]           rsp_selected_total;
   logic                  rsp_final_res;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // filter settings as the block should hold them
   logic [63:0] pat_reg [PAT_REGS];
   logic [5:0]  pat_len_cfg;
   logic        fold_cfg;
   logic        invert_cfg;

   // line state of the model
   logic [7:0]  tail_bytes [PAT_MAX];
   logic [8:0]  line_len;
   logic        hit_flag;
   logic        nul_flag;
   count_type   line_cnt;
   count_type   sel_cnt;

   line_report_type line_reports [$];

   int mismatches;
   int stuck_cycles;
   int random_items;
   int hold_request;
   bit send_idle;
   bit sink_idle;

   line_substring_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_valid     (rsp_line_valid),
      .rsp_line_selected  (rsp_line_selected),
      .rsp_line_number    (rsp_line_number),
      .rsp_selected_total (rsp_selected_total),
      .rsp_final_res      (rsp_final_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // line model
   // ------------------------------------------------------------------
   function automatic logic [7:0] case_fold(input logic [7:0] c);
      if (fold_cfg && c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic int active_len();
      return (pat_len_cfg > PAT_MAX) ? PAT_MAX : int'(pat_len_cfg);
   endfunction

   function automatic logic [7:0] pat_at(input int k);
      if (k >= PAT_BYTES) begin
         return 8'h00;
      end
      return pat_reg[k / 8][(k % 8) * 8 +: 8];
   endfunction

   function automatic logic window_hit();
      int n;
      int k;
      n = active_len();
      if (n == 0 || line_len < n) begin
         return 1'b0;
      end
      for (k = 0; k < n; k++) begin
         if (case_fold(tail_bytes[n - 1 - k]) != case_fold(pat_at(k))) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void clear_line();
      int k;
      for (k = 0; k < PAT_MAX; k++) begin
         tail_bytes[k] = 8'h00;
      end
      line_len = '0;
      hit_flag = 1'b0;
      nul_flag = 1'b0;
   endfunction

   function automatic void close_line(input logic is_final);
      line_report_type r;
      logic sel;
      sel = (hit_flag || active_len() == 0) ^ invert_cfg;
      if (line_cnt != '1) begin
         line_cnt++;
      end
      if (sel && sel_cnt != '1) begin
         sel_cnt++;
      end
      r.line_valid     = 1'b1;
      r.line_selected  = sel;
      r.line_number    = line_cnt;
      r.selected_total = sel_cnt;
      r.final_res      = is_final;
      line_reports.push_back(r);
      clear_line();
   endfunction

   function automatic void filter_byte(input logic [7:0] b, input logic eoi);
      line_report_type r;
      int k;
      if (eoi) begin
         if (line_len > 0) begin
            close_line(1'b1);
         end else begin
            r.line_valid     = 1'b0;
            r.line_selected  = 1'b0;
            r.line_number    = line_cnt;
            r.selected_total = sel_cnt;
            r.final_res      = 1'b1;
            line_reports.push_back(r);
            clear_line();
         end
         line_cnt = '0;
         return;
      end
      if (b == LF_BYTE) begin
         close_line(1'b0);
         return;
      end
      for (k = PAT_MAX - 1; k > 0; k--) begin
         tail_bytes[k] = tail_bytes[k - 1];
      end
      tail_bytes[0] = b;
      if (line_len < LINE_MAX - 1) begin
         line_len++;
      end
      if (b == NUL_BYTE) begin
         nul_flag = 1'b1;
      end else if (!nul_flag && window_hit()) begin
         hit_flag = 1'b1;
      end
      // line buffer full: split here
      if (line_len >= LINE_MAX - 1) begin
         close_line(1'b0);
      end
   endfunction

   function automatic void apply_csr(input csr_index_type idx, input logic [63:0] val);
      case (idx)
         CSR_PAT_LO:     pat_reg[0] = val;
         CSR_PAT_MID_LO: pat_reg[1] = val;
         CSR_PAT_MID_HI: pat_reg[2] = val;
         CSR_PAT_HI:     pat_reg[3] = val;
         CSR_PAT_LEN:    pat_len_cfg = val[5:0];
         CSR_FOLD_CASE:  fold_cfg = val[0];
         CSR_INVERT:     invert_cfg = val[0];
         default: ;
      endcase
   endfunction

   function automatic csr_index_type pattern_reg(input int r);
      case (r)
         0:       return CSR_PAT_LO;
         1:       return CSR_PAT_MID_LO;
         2:       return CSR_PAT_MID_HI;
         default: return CSR_PAT_HI;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [7:0] random_letter();
      logic [7:0] c;
      c = 8'h61 + 8'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) begin
         c = c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = active_len();
      if (r < 55) begin
         return random_letter();
      end else if (r < 70) begin
         return pat_at($urandom_range(0, (n > 0) ? n - 1 : 0));
      end else if (r < 90) begin
         return 8'($urandom_range(0, 255));
      end else if (r < 93) begin
         return NUL_BYTE;
      end else if (r < 96) begin
         return 8'h0D;
      end
      return 8'hFF;
   endfunction

   function automatic logic [255:0] random_pattern();
      logic [255:0] p;
      int k;
      if ($urandom_range(0, 9) == 0) begin
         for (k = 0; k < 8; k++) begin
            p[32 * k +: 32] = $urandom;
         end
      end else begin
         for (k = 0; k < PAT_BYTES; k++) begin
            p[8 * k +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : random_letter();
         end
      end
      return p;
   endfunction

   function automatic logic [5:0] random_length();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 6'd0;
      end else if (r <= 5) begin
         return 6'($urandom_range(1, 4));
      end else if (r <= 7) begin
         return 6'($urandom_range(5, 12));
      end else if (r == 8) begin
         case ($urandom_range(0, 2))
            0:       return 6'd32;
            1:       return 6'd33;
            default: return 6'd63;
         endcase
      end
      return 6'($urandom_range(0, 63));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eoi);
      int gap;
      gap = send_idle ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      filter_byte(b, eoi);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_byte(s[i], 1'b0);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (line_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // pattern byte 0 is the low byte of pat; unused upper bits of the small
   // registers carry junk that the block has to ignore
   task automatic set_filter(input logic [255:0] pat, input logic [5:0] len,
                             input logic fold, input logic inv);
      int r;
      drain_results();
      for (r = 0; r < PAT_REGS; r++) begin
         write_csr(pattern_reg(r), pat[64 * r +: 64]);
      end
      write_csr(CSR_PAT_LEN, {$urandom, 26'($urandom), len});
      write_csr(CSR_FOLD_CASE, {$urandom, 31'($urandom), fold});
      write_csr(CSR_INVERT, {$urandom, 31'($urandom), inv});
   endtask

   task automatic send_random_line();
      logic [7:0] text [$];
      int n;
      int pos;
      int k;
      logic [7:0] c;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
      for (k = 0; k < n; k++) begin
         text.push_back(pick_text_byte());
      end
      if (active_len() > 0 && $urandom_range(0, 99) < 45) begin
         pos = $urandom_range(0, text.size());
         for (k = 0; k < active_len(); k++) begin
            c = pat_at(k);
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                && $urandom_range(0, 3) == 0) begin
               c = c ^ 8'h20;
            end
            text.insert(pos + k, c);
         end
      end
      foreach (text[i]) begin
         send_byte(text[i], 1'b0);
      end
      if ($urandom_range(0, 9) == 0) begin
         send_byte(8'($urandom), 1'b1);
      end else begin
         send_byte(LF_BYTE, 1'b0);
      end
      random_items += text.size() + 1;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_match_and_flush();
      // pattern "aB" with case folding
      set_filter(256'("Ba"), 6'd2, 1'b1, 1'b0);
      send_text("xAb\n");
      send_text("\n");
      send_byte(NUL_BYTE, 1'b0);
      send_text("ab\n");
      send_byte(8'hFF, 1'b1);
      send_text("ab");
      send_byte(8'h00, 1'b1);
      send_byte(8'hA5, 1'b1);
   endtask

   task automatic test_empty_pattern_invert();
      set_filter(256'("ab"), 6'd0, 1'b0, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(LF_BYTE, 1'b0);
      send_byte(LF_BYTE, 1'b0);
      set_filter(256'("ab"), 6'd0, 1'b0, 1'b0);
      send_byte(LF_BYTE, 1'b0);
      // CR inside the pattern is an ordinary byte
      set_filter(256'(8'h0D), 6'd1, 1'b0, 1'b0);
      send_text("a");
      send_byte(8'h0D, 1'b0);
      send_text("b\n");
   endtask

   task automatic test_long_lines();
      int k;
      set_filter(256'("dc"), 6'd2, 1'b0, 1'b0);
      // hit a few bytes before the split, then an lf that ends an empty line
      for (k = 0; k < LINE_MAX - 7; k++) begin
         send_byte(random_letter(), 1'b0);
      end
      send_text("cd");
      for (k = 0; k < 4; k++) begin
         send_byte(random_letter(), 1'b0);
      end
      send_byte(LF_BYTE, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_backpressure();
      int k;
      set_filter(256'("ba"), 6'd2, 1'b0, 1'b0);
      send_idle    = 1'b0;
      hold_request = HOLD_CYCLES;
      for (k = 0; k < 30; k++) begin
         send_text(($urandom_range(0, 1) == 1) ? "ab\n" : "xy\n");
      end
      send_idle = 1'b1;
   endtask

   task automatic test_random_traffic();
      int lines;
      int k;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         set_filter(random_pattern(), random_length(), 1'($urandom), 1'($urandom));
         send_idle = ($urandom_range(0, 3) != 0);
         sink_idle = ($urandom_range(0, 3) != 0);
         lines = $urandom_range(2, 6);
         for (k = 0; k < lines; k++) begin
            send_random_line();
         end
      end
      send_idle = 1'b1;
      sink_idle = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // result side: random stall per transaction, one long hold on request
   // ------------------------------------------------------------------
   initial begin : result_sink
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = sink_idle ? $urandom_range(0, 10) : 0;
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ------------------------------------------------------------------
   // checker and watchdog
   // ------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_reports
      line_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none actual line_number %0d",
                     $time, rsp_line_number);
         end else begin
            want = line_reports.pop_front();
            check_field("line_valid", 32'(want.line_valid), 32'(rsp_line_valid));
            check_field("line_selected", 32'(want.line_selected),
                        32'(rsp_line_selected));
            check_field("line_number", want.line_number, rsp_line_number);
            check_field("selected_total", want.selected_total, rsp_selected_total);
            check_field("final_res", 32'(want.final_res), 32'(rsp_final_res));
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = 8'h00;
      req_end_of_input = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_PAT_LO;
      csr_wdata        = '0;
      mismatches       = 0;
      stuck_cycles     = 0;
      hold_request     = 0;
      send_idle        = 1'b1;
      sink_idle        = 1'b1;
      pat_reg          = '{default: 64'h0};
      pat_len_cfg      = '0;
      fold_cfg         = 1'b0;
      invert_cfg       = 1'b0;
      line_cnt         = '0;
      sel_cnt          = '0;
      clear_line();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_match_and_flush();
      test_empty_pattern_invert();
      test_long_lines();
      test_backpressure();
      test_random_traffic();
      drain_results();

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- line_substring_filter.f -----
src/lsf_pkg.sv
src/line_substring_filter.sv
test/line_substring_filter_tb.sv
